[rtl/tths_pkg.sv]
// ----------------------------------------------------------------------------
// tths_pkg
// shared types and constants of the terrain triangle height sampler
// ----------------------------------------------------------------------------
package tths_pkg;

  localparam int MAP_SIDE_DEF = 256;
  localparam int QUEUE_DEPTH  = 4;
  localparam int TILE_LEN     = 256;
  localparam int MODE1_OFFSET = 48;
  localparam int FLAG_ROT_NEW = 4;
  localparam int FLAG_ROT_OLD = 6;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  localparam logic REG_MAP_MODE = 1'b0;
  localparam logic REG_VSCALE   = 1'b1;

  // cell word: {flag bit 6, flag bit 4, height}
  typedef struct packed {
    op_t        op;
    logic       wr_keep;
    logic       oor;
    logic [9:0] cell_word;
    logic [7:0] dx;
    logic [7:0] dz;
  } tths_item_t;

  typedef struct packed {
    logic        map_mode;
    logic [15:0] vscale;
  } tths_cfg_t;

endpackage

[rtl/tths_if.sv]
// ----------------------------------------------------------------------------
// tths_in_if / tths_out_if
// valid/ready channels for input items and results
// ----------------------------------------------------------------------------
interface tths_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] cell_address;
  logic [7:0]  cell_height;
  logic [15:0] cell_flags;
  logic [15:0] pos_x;
  logic [15:0] pos_z;

  modport source (output valid, operation, cell_address, cell_height, cell_flags,
                  pos_x, pos_z, input ready);
  modport sink (input valid, operation, cell_address, cell_height, cell_flags,
                pos_x, pos_z, output ready);
endinterface

interface tths_out_if;
  logic               valid;
  logic               ready;
  logic signed [33:0] height_fixed;
  logic               out_of_range;

  modport source (output valid, height_fixed, out_of_range, input ready);
  modport sink (input valid, height_fixed, out_of_range, output ready);
endinterface

[rtl/terrain_triangle_height_sampler.sv]
// ----------------------------------------------------------------------------
// terrain_triangle_height_sampler
// height map store with triangle-interpolated, scaled height queries
// ----------------------------------------------------------------------------
// Takes one item per clock while the queue has room, writes and queries
// alike, and returns one result per item in order from the registered
// stages; a four-entry queue sits between intake and the sampling pipeline.
// The rate is set by the four corner reads per query, served by two copies
// of the cell store with two read ports each. The store is not cleared at
// reset: a query must only touch cells that were written before.
module terrain_triangle_height_sampler #(
  parameter int MAP_SIDE = tths_pkg::MAP_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tths_in_if.sink     in_ch,
  tths_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import tths_pkg::*;

  localparam int AW = $clog2(MAP_SIDE * MAP_SIDE);
  localparam int QW = AW + $bits(tths_item_t);

  logic        map_mode_r;
  logic [15:0] vscale_r;
  tths_cfg_t   cfg;
  logic        cfg_wr;

  logic          f_push, q_full, q_pop, q_valid;
  logic [AW-1:0] f_addr, q_addr;
  tths_item_t    f_item, q_item;
  logic [QW-1:0] q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r <= 1'b0;
      vscale_r   <= 16'd256;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAP_MODE) begin
        map_mode_r <= pwdata[0];
      end else begin
        vscale_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_VSCALE) ? {16'b0, vscale_r}
                                           : {31'b0, map_mode_r};

  assign cfg.map_mode = map_mode_r;
  assign cfg.vscale   = vscale_r;

  tths_front #(.MAP_SIDE(MAP_SIDE), .AW(AW)) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (f_push),
    .q_addr (f_addr),
    .q_item (f_item)
  );

  tths_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_data  ({f_addr, f_item}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign q_addr = q_head[QW-1 -: AW];
  assign q_item = q_head[$bits(tths_item_t)-1:0];

  tths_back #(.MAP_SIDE(MAP_SIDE), .AW(AW)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_addr  (q_addr),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[rtl/tths_ram.sv]
// ----------------------------------------------------------------------------
// tths_ram
// cell store copy with one write port and two registered read ports
// ----------------------------------------------------------------------------
module tths_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

[rtl/tths_queue.sv]
// ----------------------------------------------------------------------------
// tths_queue
// short fifo between the classify front and the sampling back end
// ----------------------------------------------------------------------------
module tths_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/tths_front.sv]
// ----------------------------------------------------------------------------
// tths_front
// accepts items, classifies writes and queries, forms the anchor cell address
// ----------------------------------------------------------------------------
module tths_front #(
  parameter int MAP_SIDE = tths_pkg::MAP_SIDE_DEF,
  parameter int AW       = $clog2(MAP_SIDE * MAP_SIDE)
) (
  tths_in_if.sink              in_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [AW-1:0]        q_addr,
  output tths_pkg::tths_item_t q_item
);

  import tths_pkg::*;

  localparam int CELL_COUNT = MAP_SIDE * MAP_SIDE;
  localparam int TW = ($clog2(MAP_SIDE + 1) > 9) ? $clog2(MAP_SIDE + 1) : 9;
  localparam int LW = (AW + 1 > 17) ? AW + 1 : 17;
  localparam int MW = AW + 9;

  logic [7:0]    tx, tz;
  logic          in_map;
  logic [MW-1:0] base;
  logic          is_query;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid;

  assign tx       = in_ch.pos_x[15:8];
  assign tz       = in_ch.pos_z[15:8];
  assign is_query = (in_ch.operation == OP_QUERY);
  assign in_map   = (TW'(tx) + TW'(1) < TW'(MAP_SIDE)) && (TW'(tz) + TW'(1) < TW'(MAP_SIDE));
  assign base     = MW'(tz) * MW'(MAP_SIDE) + MW'(tx);

  always_comb begin
    q_item.op        = is_query ? OP_QUERY : OP_WRITE;
    q_item.wr_keep   = !is_query && (LW'(in_ch.cell_address) < LW'(CELL_COUNT));
    q_item.oor       = is_query && !in_map;
    q_item.cell_word = {in_ch.cell_flags[FLAG_ROT_OLD], in_ch.cell_flags[FLAG_ROT_NEW],
                        in_ch.cell_height};
    q_item.dx        = in_ch.pos_x[7:0];
    q_item.dz        = in_ch.pos_z[7:0];
    q_addr           = is_query ? base[AW-1:0] : AW'(in_ch.cell_address);
  end

endmodule

[rtl/tths_back.sv]
// ----------------------------------------------------------------------------
// tths_back
// cell store, corner reads, triangle pick and the interpolation pipeline
// ----------------------------------------------------------------------------
module tths_back #(
  parameter int MAP_SIDE = tths_pkg::MAP_SIDE_DEF,
  parameter int AW       = $clog2(MAP_SIDE * MAP_SIDE)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tths_pkg::tths_cfg_t  cfg,
  input  logic                 q_valid,
  input  logic [AW-1:0]        q_addr,
  input  tths_pkg::tths_item_t q_item,
  output logic                 q_pop,
  tths_out_if.source           out_ch
);

  import tths_pkg::*;

  localparam int CELL_COUNT = MAP_SIDE * MAP_SIDE;

  logic          adv;
  logic          we;
  logic [AW-1:0] a1, a2, a3;
  logic [9:0]    rd0, rd1, rd2, rd3;

  // stage 1: corner data
  logic       v1_r;
  tths_item_t it1_r;
  // stage 2: corners after extrapolation
  logic              v2_r, z2_r, oor2_r;
  logic signed [10:0] c0_r, c1_r, c2_r, c3_r;
  logic [7:0]        dx2_r, dz2_r;
  logic signed [10:0] c0_nxt, c1_nxt, c2_nxt, c3_nxt;
  // stage 3: row sums
  logic              v3_r, z3_r, oor3_r;
  logic signed [20:0] r0_r, r1_r;
  logic [7:0]        dz3_r;
  logic signed [9:0] wx0, wx1;
  // stage 4: bilinear sum
  logic              v4_r, z4_r, oor4_r;
  logic signed [27:0] sum_r;
  logic signed [30:0] sum_full;
  logic signed [9:0] wz0, wz1;
  // stage 5: scaled product
  logic              v5_r, z5_r, oor5_r;
  logic signed [44:0] prod_r;
  logic signed [44:0] prod_adj;
  // result register
  logic              ov_r;
  logic signed [33:0] oh_r;
  logic              oo_r;

  logic [7:0] h0, h1, h2, h3;
  logic       rot;
  logic [8:0] ndx;

  assign adv   = !ov_r || out_ch.ready;
  assign q_pop = adv && q_valid;
  assign we    = q_pop && q_item.wr_keep;
  assign a1    = q_addr + AW'(1);
  assign a2    = q_addr + AW'(MAP_SIDE);
  assign a3    = q_addr + AW'(MAP_SIDE + 1);

  tths_ram #(.DEPTH(CELL_COUNT), .AW(AW), .DW(10)) u_ram_top (
    .clk    (clk),
    .we     (we),
    .waddr  (q_addr),
    .wdata  (q_item.cell_word),
    .re     (adv),
    .raddr0 (q_addr),
    .raddr1 (a1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  tths_ram #(.DEPTH(CELL_COUNT), .AW(AW), .DW(10)) u_ram_bot (
    .clk    (clk),
    .we     (we),
    .waddr  (q_addr),
    .wdata  (q_item.cell_word),
    .re     (adv),
    .raddr0 (a2),
    .raddr1 (a3),
    .rdata0 (rd3),
    .rdata1 (rd2)
  );

  // triangle pick and opposite corner rebuild
  always_comb begin
    h0     = rd0[7:0];
    h1     = rd1[7:0];
    h2     = rd2[7:0];
    h3     = rd3[7:0];
    rot    = cfg.map_mode ? rd0[9] : rd0[8];
    ndx    = 9'(TILE_LEN) - {1'b0, it1_r.dx};
    c0_nxt = $signed({3'b0, h0});
    c1_nxt = $signed({3'b0, h1});
    c2_nxt = $signed({3'b0, h2});
    c3_nxt = $signed({3'b0, h3});
    if (rot) begin
      if (ndx > {1'b0, it1_r.dz}) begin
        c2_nxt = c1_nxt + c3_nxt - c0_nxt;
      end else begin
        c0_nxt = c1_nxt + c3_nxt - c2_nxt;
      end
    end else begin
      if (it1_r.dx > it1_r.dz) begin
        c3_nxt = c0_nxt + c2_nxt - c1_nxt;
      end else begin
        c1_nxt = c0_nxt + c2_nxt - c3_nxt;
      end
    end
  end

  assign wx0 = $signed(10'(TILE_LEN) - {2'b0, dx2_r});
  assign wx1 = $signed({2'b0, dx2_r});
  assign wz0 = $signed(10'(TILE_LEN) - {2'b0, dz3_r});
  assign wz1 = $signed({2'b0, dz3_r});

  assign sum_full = r0_r * wz0 + r1_r * wz1
                  - (cfg.map_mode ? 31'sd3145728 : 31'sd0);

  assign prod_adj = prod_r[44] ? prod_r + 45'sd255 : prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      ov_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r  <= q_item;
      z2_r   <= (it1_r.op != OP_QUERY) || it1_r.oor;
      oor2_r <= it1_r.oor;
      c0_r   <= c0_nxt;
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      c3_r   <= c3_nxt;
      dx2_r  <= it1_r.dx;
      dz2_r  <= it1_r.dz;
      z3_r   <= z2_r;
      oor3_r <= oor2_r;
      r0_r   <= c0_r * wx0 + c1_r * wx1;
      r1_r   <= c3_r * wx0 + c2_r * wx1;
      dz3_r  <= dz2_r;
      z4_r   <= z3_r;
      oor4_r <= oor3_r;
      sum_r  <= sum_full[27:0];
      z5_r   <= z4_r;
      oor5_r <= oor4_r;
      prod_r <= sum_r * $signed({1'b0, cfg.vscale});
      oh_r   <= z5_r ? '0 : prod_adj[41:8];
      oo_r   <= oor5_r;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.height_fixed = oh_r;
  assign out_ch.out_of_range = oo_r;

endmodule
